// ----- design/aws_pkg.sv -----
// ----------------------------------------------------------------------------
// aws_pkg
// Shared types, constants and helpers for the array steering weight core.
// ----------------------------------------------------------------------------
`default_nettype none

package aws_pkg;

    localparam int ATAN_ENTRIES        = 24;
    localparam int DEF_CORDIC_STAGES   = 16;
    localparam int CORDIC_XW           = 34;   // CORDIC x/y datapath width
    localparam int CORDIC_ZW           = 33;   // CORDIC residual angle width
    localparam int TRIG_W              = 32;   // cos/sin result width, Q.30
    localparam int ANG_W               = 32;   // angle, 2^32 is one turn
    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [15:0] SCALE_RESET = 16'd32768;

    typedef struct packed {
        logic               mode;
        logic [15:0]        inclination;
        logic [15:0]        azimuth;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] weight_re;
        logic signed [15:0] weight_im;
    } t_out_item;

    // atan(2^-i) in 32-bit turns.
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] r;
        if (v > 50'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -50'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/array_steering_weight_core.sv -----
// From input transfer to output valid an item passes the inclination and azimuth
// CORDIC cells, the direction and dot-product rows, the phase CORDIC and the output rows.
// Throughput: one element per cycle; every stage is a register row that
// advances together, held only while the output register waits for a transfer.
// Reset clears all valid bits and loads r_scale with one (32768).
// ----------------------------------------------------------------------------
// array_steering_weight_core
// Phased-array element weight: direction vector, dot product with position,
// phase CORDIC, and steering or scaled conjugate beamforming output.
// ----------------------------------------------------------------------------
`default_nettype none

module array_steering_weight_core #(
    parameter int CORDIC_STAGES = aws_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire aws_pkg::t_in_item i_in,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output aws_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_data
);

    localparam int TW = aws_pkg::TRIG_W;

    logic en;
    logic [15:0] r_scale;

    logic v_inc, v_az, v_ph;
    logic signed [TW-1:0] ci, si, ca, sa, cp, sp;
    logic [16:0] side_inc;
    logic [31:0] side_az;
    logic        side_ph;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7;
    logic signed [15:0] r_px1, r_py1, r_pz1, r_px2, r_py2, r_pz2, r_px3, r_py3, r_pz3;
    logic signed [TW-1:0] r_ci1, r_si1, r_ca1, r_sa1, r_uz2, r_ux3, r_uy3, r_uz3;
    logic signed [63:0] r_pxa2, r_pya2;
    logic signed [47:0] r_tx4, r_ty4, r_tz4;
    logic signed [49:0] r_dot5, neg_dot;
    logic signed [TW-1:0] r_cp6, r_sp6;
    logic signed [49:0] r_re7, r_im7;
    logic signed [63:0] ux_full, uy_full;
    logic signed [49:0] re_rnd, im_rnd;
    logic [31:0] ph;
    logic signed [16:0] k;
    logic signed [32:0] sp_neg;

    logic r_ov;
    aws_pkg::t_out_item r_out;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= aws_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    aws_cordic_chain #(.STAGES(CORDIC_STAGES), .SIDE_W(17)) u_inc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ang   ({i_in.inclination, 16'd0}),
        .i_side  ({i_in.mode, i_in.pos_x}),
        .o_valid (v_inc),
        .o_cos   (ci),
        .o_sin   (si),
        .o_side  (side_inc)
    );

    aws_cordic_chain #(.STAGES(CORDIC_STAGES), .SIDE_W(32)) u_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ang   ({i_in.azimuth, 16'd0}),
        .i_side  ({i_in.pos_y, i_in.pos_z}),
        .o_valid (v_az),
        .o_cos   (ca),
        .o_sin   (sa),
        .o_side  (side_az)
    );

    assign ux_full = (r_pxa2 + 64'sd536870912) >>> 30;
    assign uy_full = (r_pya2 + 64'sd536870912) >>> 30;
    assign neg_dot = 50'sd0 - r_dot5;
    assign ph      = neg_dot[37:6];

    aws_cordic_chain #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_ph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_ang   (ph),
        .i_side  (r_m5),
        .o_valid (v_ph),
        .o_cos   (cp),
        .o_sin   (sp),
        .o_side  (side_ph)
    );

    assign k      = $signed({1'b0, r_scale});
    assign sp_neg = -$signed({r_sp6[TW-1], r_sp6});

    // Rounding of the last stage depends on the mode: Q.30 to Q.15 for steering,
    // and the Q.30 times Q1.15 product back to Q.15 for beamforming.
    assign re_rnd = r_m7 ? ((r_re7 + 50'sd536870912) >>> 30) : ((r_re7 + 50'sd16384) >>> 15);
    assign im_rnd = r_m7 ? ((r_im7 + 50'sd536870912) >>> 30) : ((r_im7 + 50'sd16384) >>> 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= v_inc && v_az;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= v_ph;
            r_v7 <= r_v6;
            r_ov <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ci1  <= ci;
            r_si1  <= si;
            r_ca1  <= ca;
            r_sa1  <= sa;
            r_m1   <= side_inc[16];
            r_px1  <= side_inc[15:0];
            r_py1  <= side_az[31:16];
            r_pz1  <= side_az[15:0];

            r_pxa2 <= r_si1 * r_ca1;
            r_pya2 <= r_si1 * r_sa1;
            r_uz2  <= r_ci1;
            r_m2   <= r_m1;
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_pz2  <= r_pz1;

            r_ux3  <= ux_full[TW-1:0];
            r_uy3  <= uy_full[TW-1:0];
            r_uz3  <= r_uz2;
            r_m3   <= r_m2;
            r_px3  <= r_px2;
            r_py3  <= r_py2;
            r_pz3  <= r_pz2;

            r_tx4  <= r_ux3 * r_px3;
            r_ty4  <= r_uy3 * r_py3;
            r_tz4  <= r_uz3 * r_pz3;
            r_m4   <= r_m3;

            r_dot5 <= 50'(r_tx4) + 50'(r_ty4) + 50'(r_tz4);
            r_m5   <= r_m4;

            r_cp6  <= cp;
            r_sp6  <= sp;
            r_m6   <= side_ph;

            if (r_m6) begin
                r_re7 <= r_cp6 * k;
                r_im7 <= sp_neg * k;
            end else begin
                r_re7 <= 50'(r_cp6);
                r_im7 <= 50'(r_sp6);
            end
            r_m7   <= r_m6;

            r_out.weight_re <= aws_pkg::sat16(re_rnd);
            r_out.weight_im <= aws_pkg::sat16(im_rnd);
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !r_v7) |=> !o_valid)
        else $error("output valid without an item in the last stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_v5) && $stable(r_dot5)))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ----- design/aws_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// aws_cordic_cell
// One rotation-mode CORDIC micro-rotation with its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aws_cordic_cell #(
    parameter int IDX    = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic signed [aws_pkg::CORDIC_XW-1:0]  i_x,
    input  wire logic signed [aws_pkg::CORDIC_XW-1:0]  i_y,
    input  wire logic signed [aws_pkg::CORDIC_ZW-1:0]  i_z,
    input  wire logic [SIDE_W-1:0]                     i_side,
    output logic                                       o_valid,
    output logic signed [aws_pkg::CORDIC_XW-1:0]       o_x,
    output logic signed [aws_pkg::CORDIC_XW-1:0]       o_y,
    output logic signed [aws_pkg::CORDIC_ZW-1:0]       o_z,
    output logic [SIDE_W-1:0]                          o_side
);

    logic signed [aws_pkg::CORDIC_XW-1:0] dx, dy, n_x, n_y;
    logic signed [aws_pkg::CORDIC_ZW-1:0] atn, n_z;
    logic r_valid;
    logic signed [aws_pkg::CORDIC_XW-1:0] r_x, r_y;
    logic signed [aws_pkg::CORDIC_ZW-1:0] r_z;
    logic [SIDE_W-1:0] r_side;

    assign atn = $signed({1'b0, aws_pkg::atan_turn(IDX)});
    assign dx  = i_y >>> IDX;
    assign dy  = i_x >>> IDX;

    always_comb begin
        if (!i_z[aws_pkg::CORDIC_ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - atn;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + atn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ----- design/aws_cordic_chain.sv -----
// ----------------------------------------------------------------------------
// aws_cordic_chain
// Quadrant split, a row of CORDIC cells, and the quadrant fold-back.
// ----------------------------------------------------------------------------
`default_nettype none

module aws_cordic_chain #(
    parameter int STAGES = aws_pkg::DEF_CORDIC_STAGES,
    parameter int SIDE_W = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [aws_pkg::ANG_W-1:0]           i_ang,
    input  wire logic [SIDE_W-1:0]                   i_side,
    output logic                                     o_valid,
    output logic signed [aws_pkg::TRIG_W-1:0]        o_cos,
    output logic signed [aws_pkg::TRIG_W-1:0]        o_sin,
    output logic [SIDE_W-1:0]                        o_side
);

    localparam int XW = aws_pkg::CORDIC_XW;
    localparam int ZW = aws_pkg::CORDIC_ZW;
    localparam int TW = aws_pkg::TRIG_W;
    localparam int CW = SIDE_W + 2;

    logic [aws_pkg::ANG_W-1:0] ang_rnd, res;
    logic [1:0] quad, q_out;

    logic                 v_s [STAGES+1];
    logic signed [XW-1:0] x_s [STAGES+1];
    logic signed [XW-1:0] y_s [STAGES+1];
    logic signed [ZW-1:0] z_s [STAGES+1];
    logic [CW-1:0]        c_s [STAGES+1];

    logic signed [XW-1:0] xf, yf, nx, ny;

    assign ang_rnd = i_ang + 32'h2000_0000;
    assign quad    = ang_rnd[31:30];
    assign res     = i_ang - {quad, 30'd0};

    assign v_s[0] = i_valid;
    assign x_s[0] = aws_pkg::CORDIC_GAIN;
    assign y_s[0] = '0;
    assign z_s[0] = $signed({res[31], res});
    assign c_s[0] = {quad, i_side};

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        aws_cordic_cell #(
            .IDX    (g),
            .SIDE_W (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (v_s[g]),
            .i_x     (x_s[g]),
            .i_y     (y_s[g]),
            .i_z     (z_s[g]),
            .i_side  (c_s[g]),
            .o_valid (v_s[g+1]),
            .o_x     (x_s[g+1]),
            .o_y     (y_s[g+1]),
            .o_z     (z_s[g+1]),
            .o_side  (c_s[g+1])
        );
    end

    // The final residual angle is not needed.
    assign xf    = x_s[STAGES];
    assign yf    = y_s[STAGES];
    assign q_out = c_s[STAGES][CW-1:CW-2];
    assign nx    = -xf;
    assign ny    = -yf;

    always_comb begin
        case (q_out)
            2'd0:    begin o_cos = xf[TW-1:0]; o_sin = yf[TW-1:0]; end
            2'd1:    begin o_cos = ny[TW-1:0]; o_sin = xf[TW-1:0]; end
            2'd2:    begin o_cos = nx[TW-1:0]; o_sin = ny[TW-1:0]; end
            default: begin o_cos = yf[TW-1:0]; o_sin = nx[TW-1:0]; end
        endcase
    end

    assign o_valid = v_s[STAGES];
    assign o_side  = c_s[STAGES][SIDE_W-1:0];

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Array steering weight core testbench
// Drives element positions and beam directions through the core under
// random sender and receiver idling, predicts each weight with a bit-accurate
// CORDIC model or takes it from the stimulus, and compares each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int STAGES     = aws_pkg::DEF_CORDIC_STAGES;
    localparam int LATENCY    = 2 * STAGES + 8;
    localparam int N_RANDOM   = 1000;
    localparam int STALL_MAX  = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    aws_pkg::t_in_item   i_in;
    logic                o_valid;
    logic                i_ready;
    aws_pkg::t_out_item  o_out;
    logic                i_cfg_we;
    logic [15:0]         i_cfg_data;

    array_steering_weight_core #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    logic [15:0]         scale_now;
    aws_pkg::t_out_item  pending_weights[$];
    int                  errors;
    int                  idle_cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  sent_count;
    bit                  recv_hold;
    int                  hold_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    function automatic void rotate_turns(input logic [31:0] ang, output longint c,
                                         output longint s);
        logic [31:0] quad;
        logic [31:0] resid;
        longint      x, y, z, dx, dy;
        quad  = ((ang + 32'h20000000) >> 30) & 32'd3;
        resid = ang - (quad << 30);
        z = longint'(resid);
        if (resid[31]) z = z - (64'sd1 <<< 32);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic aws_pkg::t_out_item element_weight(aws_pkg::t_in_item it,
                                                          logic [15:0] scale);
        longint    ci, si, ca, sa, ux, uy, uz, dot, cp, sp;
        logic [63:0] neg;
        aws_pkg::t_out_item w;
        rotate_turns({it.inclination, 16'h0}, ci, si);
        rotate_turns({it.azimuth, 16'h0}, ca, sa);
        ux  = shr_floor(si * ca + (64'sd1 <<< 29), 30);
        uy  = shr_floor(si * sa + (64'sd1 <<< 29), 30);
        uz  = ci;
        dot = ux * longint'(it.pos_x) + uy * longint'(it.pos_y) + uz * longint'(it.pos_z);
        neg = 64'd0 - 64'(dot);
        rotate_turns(neg[37:6], cp, sp);
        if (it.mode) begin
            w.weight_re = clip16(shr_floor(cp * longint'(scale) + (64'sd1 <<< 29), 30));
            w.weight_im = clip16(shr_floor(-sp * longint'(scale) + (64'sd1 <<< 29), 30));
        end else begin
            w.weight_re = clip16(shr_floor(cp + (64'sd1 <<< 14), 15));
            w.weight_im = clip16(shr_floor(sp + (64'sd1 <<< 14), 15));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver idling, checking and the watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_weights.size() == 0) begin
                $display("%0t: unexpected weight transfer re=%0d im=%0d",
                         $time, o_out.weight_re, o_out.weight_im);
                errors++;
            end else begin
                aws_pkg::t_out_item w;
                w = pending_weights.pop_front();
                if (w.weight_re !== o_out.weight_re) begin
                    $display("%0t: weight_re expected %0d actual %0d",
                             $time, w.weight_re, o_out.weight_re);
                    errors++;
                end
                if (w.weight_im !== o_out.weight_im) begin
                    $display("%0t: weight_im expected %0d actual %0d",
                             $time, w.weight_im, o_out.weight_im);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Long receiver hold-off so the pipeline fills and back-pressures input.
    // It starts inside the first random run, while the sender keeps offering.
    initial begin
        recv_hold = 1'b0;
        hold_len  = 0;
        wait (i_rst_n);
        wait (sent_count >= 100);
        @(posedge i_clk);
        recv_hold = 1'b1;
        while (hold_len < 200) begin
            @(posedge i_clk);
            hold_len++;
        end
        recv_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_element(input aws_pkg::t_in_item it, input bit use_typed,
                                input aws_pkg::t_out_item typed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in    <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_weights.push_back(use_typed ? typed : element_weight(it, scale_now));
        sent_count++;
    endtask

    task automatic drain_then_write(input logic [15:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scale_now = value;
    endtask

    function automatic aws_pkg::t_in_item rand_element(bit small_pos);
        aws_pkg::t_in_item it;
        it.mode        = 1'($urandom_range(1));
        it.inclination = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        it.azimuth     = 16'($urandom);
        if (small_pos) begin
            it.pos_x = 16'($signed($urandom_range(4096)) - 2048);
            it.pos_y = 16'($signed($urandom_range(4096)) - 2048);
            it.pos_z = 16'($signed($urandom_range(4096)) - 2048);
        end else begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
        end
        return it;
    endfunction

    typedef struct {
        aws_pkg::t_in_item  it;
        bit                 typed;
        aws_pkg::t_out_item w;
    } t_stim_row;

    t_stim_row directed_rows[] = '{
        // Zero position: phase zero, the real part saturates at one and the
        // imaginary part carries the CORDIC residual.
        '{'{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0}},
        '{'{1'b1, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0}},
        '{'{1'b0, 16'd32768, 16'd65535, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '{0, 0}},
        '{'{1'b0, 16'd32768, 16'd0, -16'sh8000, -16'sh8000, -16'sh8000}, 1'b0, '{0, 0}},
        '{'{1'b1, 16'd16384, 16'd16384, 16'sd128, 16'sd0, 16'sd0}, 1'b0, '{0, 0}},
        '{'{1'b0, 16'd16384, 16'd0, 16'sd128, 16'sd0, 16'sd0}, 1'b0, '{0, 0}},
        '{'{1'b0, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd64}, 1'b0, '{0, 0}},
        '{'{1'b1, 16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd64}, 1'b0, '{0, 0}},
        // Inclination above pi is used as encoded.
        '{'{1'b0, 16'd49152, 16'd8192, 16'sd300, -16'sd77, 16'sd5}, 1'b0, '{0, 0}},
        '{'{1'b1, 16'hFFFF, 16'hFFFF, 16'shFFFF, 16'sh0001, 16'sh5555}, 1'b0, '{0, 0}},
        '{'{1'b0, 16'd8192, 16'd49152, 16'shAAAA, 16'sh5555, -16'sd1}, 1'b0, '{0, 0}},
        '{'{1'b1, 16'd24576, 16'd32768, 16'sd32, 16'sd96, -16'sd128}, 1'b0, '{0, 0}}
    };

    initial begin
        errors        = 0;
        idle_cycles   = 0;
        sent_count    = 0;
        scale_now     = aws_pkg::SCALE_RESET;
        send_idle_pct = 12;
        recv_idle_pct = 54;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in          = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_element(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].w);

        // Scale extremes, including zero and above one (output saturates).
        drain_then_write(16'd0);
        send_element('{1'b1, 16'd16384, 16'd0, 16'sd77, 16'sd0, 16'sd0}, 1'b1, '{0, 0});
        drain_then_write(16'hFFFF);
        for (int k = 0; k < 6; k++) send_element(rand_element(1'b1), 1'b0, '{0, 0});

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin drain_then_write(16'd23170); send_idle_pct = 12; recv_idle_pct = 54; end
                1: begin drain_then_write(16'd32768); send_idle_pct = 54; recv_idle_pct = 12; end
                default: begin
                    drain_then_write(16'($urandom_range(32768)));
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < N_RANDOM / 3; k++)
                send_element(rand_element($urandom_range(3) != 0), 1'b0, '{0, 0});
        end

        i_valid <= 1'b0;
        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/aws_pkg.sv
design/aws_cordic_cell.sv
design/aws_cordic_chain.sv
design/array_steering_weight_core.sv
sim/tb.sv
